@@ src/tldt_pkg.sv @@
// Shared types, codes and default sizes for the two-level directory table.
`timescale 1ns / 1ps

package tldt_pkg;

  localparam int USER_SLOTS_DEF     = 8;
  localparam int FILES_PER_USER_DEF = 16;
  localparam int KEY_BITS_DEF       = 64;

  localparam int KEY_W    = 64;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_CREATE = 2'd0,
    FN_DELETE = 2'd1,
    FN_LIST   = 2'd2,
    FN_UNUSED = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CREATED      = 4'd0,
    ST_EXISTS       = 4'd1,
    ST_NO_USER_SLOT = 4'd2,
    ST_DIR_FULL     = 4'd3,
    ST_DELETED      = 4'd4,
    ST_FILE_MISSING = 4'd5,
    ST_USER_MISSING = 4'd6,
    ST_ENTRY        = 4'd7,
    ST_LIST_EMPTY   = 4'd8,
    ST_BAD          = 4'd9
  } status_t;

  typedef struct packed {
    logic    cap;
    logic    scan_clr;
    logic    scan_run;
    logic    file_mode;
    logic    uidx_hit;
    logic    uidx_new;
    logic    claim;
    logic    load_base;
    logic    load_rem;
    logic    fcreate;
    logic    fdelete;
    logic    emit;
    status_t status;
    logic    last;
    logic    use_key;
  } dir_cmd_t;

  typedef struct packed {
    logic  bad;
    func_t func;
    logic  u_match;
    logic  u_full;
    logic  scan_done;
    logic  row_zero;
    logic  f_used;
    logic  f_match;
    logic  f_last;
    logic  free_vld;
  } dir_sts_t;

endpackage

@@ src/two_level_directory_table.sv @@
// Top level of the two-level directory table: controller plus datapath.
// A malformed request leaves busy low, and its bad-request result appears on the next cycle.
// Any other request holds busy while the user RAM and then the file RAM are scanned, one
// slot per cycle. Each result is registered and appears in the cycle after it is decided,
// and a list gives at most one entry per cycle, skipping free slots.
// Synchronous active-low reset clears controller, user count, scan state and result strobe.
`timescale 1ns / 1ps

module two_level_directory_table #(
  parameter int USER_SLOTS     = tldt_pkg::USER_SLOTS_DEF,
  parameter int FILES_PER_USER = tldt_pkg::FILES_PER_USER_DEF,
  parameter int KEY_BITS       = tldt_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tldt_pkg::FUNC_W-1:0]   in_func,
  input  logic [tldt_pkg::KEY_W-1:0]    in_user_key,
  input  logic [tldt_pkg::KEY_W-1:0]    in_file_key,
  output logic                          out_valid,
  output logic [tldt_pkg::STATUS_W-1:0] out_status,
  output logic [tldt_pkg::KEY_W-1:0]    out_entry_key,
  output logic                          out_last
);

  import tldt_pkg::*;

  dir_cmd_t cmd;
  dir_sts_t sts;

  tldt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  tldt_dp #(
    .USER_SLOTS     (USER_SLOTS),
    .FILES_PER_USER (FILES_PER_USER),
    .KEY_BITS       (KEY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_func),
    .in_user_key   (in_user_key),
    .in_file_key   (in_file_key),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_entry_key (out_entry_key),
    .out_last      (out_last)
  );

endmodule

@@ src/tldt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module tldt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/tldt_ctrl.sv @@
// Controller state machine that sequences user scan, claim and file scan.
`timescale 1ns / 1ps

module tldt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tldt_pkg::dir_sts_t sts,
  output tldt_pkg::dir_cmd_t cmd
);

  import tldt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_USCAN = 6'b000010,
    S_CLAIM = 6'b000100,
    S_ROW   = 6'b001000,
    S_ROW2  = 6'b010000,
    S_FSCAN = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.cap = 1'b1;
          if (sts.bad) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_BAD;
            cmd.last   = 1'b1;
          end else begin
            cmd.scan_clr = 1'b1;
            state_nxt    = S_USCAN;
          end
        end
      end
      S_USCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.u_match) begin
          cmd.uidx_hit = 1'b1;
          state_nxt    = S_ROW;
        end else if (sts.scan_done) begin
          if (sts.func == FN_CREATE) begin
            if (sts.u_full) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_NO_USER_SLOT;
              cmd.last   = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              cmd.uidx_new = 1'b1;
              state_nxt    = S_CLAIM;
            end
          end else begin
            cmd.emit   = 1'b1;
            cmd.status = ST_USER_MISSING;
            cmd.last   = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_CLAIM: begin
        // A new user starts with its first file slot holding the request.
        cmd.claim  = 1'b1;
        cmd.emit   = 1'b1;
        cmd.status = ST_CREATED;
        cmd.last   = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_ROW: begin
        cmd.load_base = 1'b1;
        state_nxt     = S_ROW2;
      end
      S_ROW2: begin
        if ((sts.func == FN_LIST) && sts.row_zero) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_LIST_EMPTY;
          cmd.last   = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.load_rem = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_FSCAN;
        end
      end
      S_FSCAN: begin
        cmd.scan_run  = 1'b1;
        cmd.file_mode = 1'b1;
        unique case (sts.func)
          FN_CREATE: begin
            if (sts.f_match) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_EXISTS;
              cmd.last   = 1'b1;
              state_nxt  = S_IDLE;
            end else if (sts.scan_done) begin
              cmd.emit  = 1'b1;
              cmd.last  = 1'b1;
              state_nxt = S_IDLE;
              if (sts.free_vld) begin
                cmd.fcreate = 1'b1;
                cmd.status  = ST_CREATED;
              end else begin
                cmd.status = ST_DIR_FULL;
              end
            end
          end
          FN_DELETE: begin
            if (sts.f_match) begin
              cmd.fdelete = 1'b1;
              cmd.emit    = 1'b1;
              cmd.status  = ST_DELETED;
              cmd.last    = 1'b1;
              state_nxt   = S_IDLE;
            end else if (sts.scan_done) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_FILE_MISSING;
              cmd.last   = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
          FN_LIST: begin
            if (sts.f_used) begin
              cmd.emit    = 1'b1;
              cmd.status  = ST_ENTRY;
              cmd.use_key = 1'b1;
              cmd.last    = sts.f_last;
              if (sts.f_last) begin
                state_nxt = S_IDLE;
              end
            end else if (sts.scan_done) begin
              state_nxt = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ src/tldt_dp.sv @@
// Datapath: request registers, slot scan counter, user, bitmap and file RAMs, result registers.
`timescale 1ns / 1ps

module tldt_dp #(
  parameter int USER_SLOTS     = tldt_pkg::USER_SLOTS_DEF,
  parameter int FILES_PER_USER = tldt_pkg::FILES_PER_USER_DEF,
  parameter int KEY_BITS       = tldt_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tldt_pkg::FUNC_W-1:0]   in_func,
  input  logic [tldt_pkg::KEY_W-1:0]    in_user_key,
  input  logic [tldt_pkg::KEY_W-1:0]    in_file_key,
  input  tldt_pkg::dir_cmd_t            cmd,
  output tldt_pkg::dir_sts_t            sts,
  output logic                          out_valid,
  output logic [tldt_pkg::STATUS_W-1:0] out_status,
  output logic [tldt_pkg::KEY_W-1:0]    out_entry_key,
  output logic                          out_last
);

  import tldt_pkg::*;

  localparam int UW    = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
  localparam int UCW   = $clog2(USER_SLOTS + 1);
  localparam int FW    = (FILES_PER_USER > 1) ? $clog2(FILES_PER_USER) : 1;
  localparam int TOTAL = USER_SLOTS * FILES_PER_USER;
  localparam int FAW   = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int SMAX  = (USER_SLOTS > FILES_PER_USER) ? USER_SLOTS : FILES_PER_USER;
  localparam int SW    = $clog2(SMAX + 1);
  localparam logic [FILES_PER_USER-1:0] BIT0 = FILES_PER_USER'(1);

  logic [KEY_BITS-1:0]       ukey_in;
  logic [KEY_BITS-1:0]       fkey_in;
  func_t                     func_r;
  logic [KEY_BITS-1:0]       ukey_r;
  logic [KEY_BITS-1:0]       fkey_r;
  logic [UCW-1:0]            user_count_r;
  logic [UW-1:0]             uidx_r;
  logic [FAW-1:0]            base_r;
  logic [FAW:0]              base_full;
  logic [FAW-1:0]            base_comb;
  logic [SW-1:0]             a_r;
  logic [SW-1:0]             p_r;
  logic                      pv_r;
  logic [SW-1:0]             limit;
  logic                      issue;
  logic                      free_vld_r;
  logic [FW-1:0]             free_idx_r;
  logic [FILES_PER_USER-1:0] rem_r;
  logic [FW-1:0]             pos;
  logic [FILES_PER_USER-1:0] dec_p;
  logic [KEY_BITS-1:0]       user_rd;
  logic [KEY_BITS-1:0]       file_rd;
  logic [FILES_PER_USER-1:0] row_rd;
  logic                      row_we;
  logic [FILES_PER_USER-1:0] row_wdata;
  logic                      file_we;
  logic [FAW-1:0]            file_waddr;
  logic [FAW-1:0]            file_raddr;
  logic                      f_used;
  logic                      out_valid_r;
  status_t                   out_status_r;
  logic [KEY_W-1:0]          out_key_r;
  logic                      out_last_r;

  assign ukey_in = in_user_key[KEY_BITS-1:0];
  assign fkey_in = in_file_key[KEY_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      func_r <= func_t'(in_func);
      ukey_r <= ukey_in;
      fkey_r <= fkey_in;
    end
  end

  // Scan pipeline: a_r addresses the RAM, p_r and pv_r tag the registered read data in the cycle after.
  assign limit = cmd.file_mode ? SW'(FILES_PER_USER) : SW'(user_count_r);
  assign issue = (a_r < limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r  <= '0;
      p_r  <= '0;
      pv_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      a_r  <= '0;
      pv_r <= 1'b0;
    end else if (cmd.scan_run) begin
      pv_r <= issue;
      p_r  <= a_r;
      if (issue) begin
        a_r <= a_r + SW'(1);
      end
    end
  end

  assign base_full = (FAW+1)'(uidx_r) * (FAW+1)'(FILES_PER_USER);
  assign base_comb = base_full[FAW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_count_r <= '0;
    end else if (cmd.claim) begin
      user_count_r <= user_count_r + UCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.uidx_hit) begin
      uidx_r <= p_r[UW-1:0];
    end else if (cmd.uidx_new) begin
      uidx_r <= user_count_r[UW-1:0];
    end
    if (cmd.load_base) begin
      base_r <= base_comb;
    end
  end

  assign pos    = p_r[FW-1:0];
  assign dec_p  = BIT0 << pos;
  assign f_used = pv_r && row_rd[pos];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_vld_r <= 1'b0;
      free_idx_r <= '0;
    end else if (cmd.scan_clr) begin
      free_vld_r <= 1'b0;
    end else if (cmd.scan_run && cmd.file_mode && pv_r && !row_rd[pos] && !free_vld_r) begin
      free_vld_r <= 1'b1;
      free_idx_r <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rem) begin
      rem_r <= row_rd;
    end else if (cmd.scan_run && cmd.file_mode && f_used) begin
      rem_r <= rem_r & ~dec_p;
    end
  end

  tldt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (USER_SLOTS)
  ) u_user_ram (
    .clk   (clk),
    .we    (cmd.claim),
    .waddr (uidx_r),
    .wdata (ukey_r),
    .raddr (a_r[UW-1:0]),
    .rdata (user_rd)
  );

  assign row_we = cmd.claim || cmd.fcreate || cmd.fdelete;

  always_comb begin
    priority if (cmd.claim) begin
      row_wdata = BIT0;
    end else if (cmd.fcreate) begin
      row_wdata = row_rd | (BIT0 << free_idx_r);
    end else begin
      row_wdata = row_rd & ~dec_p;
    end
  end

  tldt_ram #(
    .WIDTH (FILES_PER_USER),
    .DEPTH (USER_SLOTS)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (uidx_r),
    .wdata (row_wdata),
    .raddr (uidx_r),
    .rdata (row_rd)
  );

  assign file_we    = cmd.claim || cmd.fcreate;
  assign file_waddr = cmd.claim ? base_comb : (base_r + FAW'(free_idx_r));
  assign file_raddr = base_r + FAW'(a_r[FW-1:0]);

  tldt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TOTAL)
  ) u_file_ram (
    .clk   (clk),
    .we    (file_we),
    .waddr (file_waddr),
    .wdata (fkey_r),
    .raddr (file_raddr),
    .rdata (file_rd)
  );

  assign sts.bad       = (in_func == FN_UNUSED) || (ukey_in == '0) ||
                         ((in_func != FN_LIST) && (fkey_in == '0));
  assign sts.func      = func_r;
  assign sts.u_match   = pv_r && (user_rd == ukey_r);
  assign sts.u_full    = (user_count_r == UCW'(USER_SLOTS));
  assign sts.scan_done = !pv_r && !issue;
  assign sts.row_zero  = (row_rd == '0);
  assign sts.f_used    = f_used;
  assign sts.f_match   = f_used && (file_rd == fkey_r);
  assign sts.f_last    = ((rem_r & ~dec_p) == '0);
  assign sts.free_vld  = free_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.status;
      out_key_r    <= cmd.use_key ? KEY_W'(file_rd) : '0;
      out_last_r   <= cmd.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_entry_key = out_key_r;
  assign out_last      = out_last_r;

endmodule

@@ src/tldt_checker.sv @@
// Port-level assertions for the directory table, bound to the top level.
`timescale 1ns / 1ps

module tldt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [tldt_pkg::FUNC_W-1:0]   in_func,
  input logic                          out_valid,
  input logic [tldt_pkg::STATUS_W-1:0] out_status,
  input logic [tldt_pkg::KEY_W-1:0]    out_entry_key,
  input logic                          out_last
);

  import tldt_pkg::*;

  a_unused_func_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FN_UNUSED)) |=>
      (out_valid && (out_status == ST_BAD) && out_last))
    else $error("unused operation did not give a bad-request result");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_ENTRY)) |-> out_last)
    else $error("non-entry result without last marker");

  a_status_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_ENTRY)) |-> (out_entry_key == '0))
    else $error("non-entry result carries a key");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("block still busy after the final result of a request");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_BAD))
    else $error("result status code out of range");

endmodule

bind two_level_directory_table tldt_checker u_tldt_checker (.*);

@@ verif/tb.sv @@
// Self-checking testbench for the two-level directory table: directed table, then random requests.
`timescale 1ns / 1ps

module tb;
  import tldt_pkg::*;

  localparam int USERS       = USER_SLOTS_DEF;
  localparam int FILES       = FILES_PER_USER_DEF;
  localparam int KEY_BITS    = KEY_BITS_DEF;
  localparam int SLOTS       = USERS * FILES;
  localparam int RAND_ITEMS  = 430;
  localparam int DRAIN_WAIT  = USERS + FILES + FILES + 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PLAN_ROWS   = 22;
  localparam int USER_POOL   = 10;
  localparam int FILE_POOL   = 22;

  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BITS >= 64) ? '1 : ((64'd1 << KEY_BITS) - 64'd1);
  localparam logic [KEY_W-1:0] KEY_A = '1;
  localparam logic [KEY_W-1:0] KEY_B = 64'd1;
  localparam logic [KEY_W-1:0] KEY_C = 64'h616c_6963_6500_0000;
  localparam logic [KEY_W-1:0] F_TOP = '1;
  localparam logic [KEY_W-1:0] F_ONE = 64'd1;
  localparam logic [KEY_W-1:0] F_MSB = 64'h8000_0000_0000_0000;
  localparam logic [KEY_W-1:0] NONE  = '0;

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] key;
    logic             last;
  } reply_t;

  typedef struct packed {
    func_t            fn;
    logic [KEY_W-1:0] ukey;
    logic [KEY_W-1:0] fkey;
    logic             typed;
    status_t          status;
    logic [KEY_W-1:0] key;
    logic             last;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [FUNC_W-1:0]   in_func;
  logic [KEY_W-1:0]    in_user_key;
  logic [KEY_W-1:0]    in_file_key;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [KEY_W-1:0]    out_entry_key;
  logic                out_last;

  logic [KEY_W-1:0] user_slot_key [USERS];
  logic [KEY_W-1:0] file_slot_key [SLOTS];
  bit               file_slot_used [SLOTS];

  reply_t           op_replies [$];
  reply_t           pending_replies [$];
  reply_t           seen_reply;
  plan_row_t        plan [PLAN_ROWS];
  logic [KEY_W-1:0] user_pool [USER_POOL];
  logic [KEY_W-1:0] file_pool [FILE_POOL];
  int               mismatches;
  int               cycle_count;

  two_level_directory_table dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_user_key   (in_user_key),
    .in_file_key   (in_file_key),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_entry_key (out_entry_key),
    .out_last      (out_last)
  );

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_reply(status_t st, logic [KEY_W-1:0] key, logic last);
    reply_t r;
    r.status = st;
    r.key    = key;
    r.last   = last;
    op_replies.push_back(r);
  endfunction

  // Applies one request to the directory copy and collects the replies it causes.
  function automatic void run_directory_op(func_t fn, logic [KEY_W-1:0] ukey_in,
                                           logic [KEY_W-1:0] fkey_in);
    logic [KEY_W-1:0] ukey;
    logic [KEY_W-1:0] fkey;
    int               u;
    int               hit;
    int               free_f;
    int               last_f;
    ukey = ukey_in & KEY_MASK;
    fkey = fkey_in & KEY_MASK;
    op_replies.delete();
    if (fn == FN_UNUSED || ukey == '0) begin
      add_reply(ST_BAD, NONE, 1'b1);
      return;
    end
    u = -1;
    for (int i = 0; i < USERS; i++) begin
      if (u < 0 && user_slot_key[i] == ukey) u = i;
    end
    if (fn == FN_LIST) begin
      if (u < 0) begin
        add_reply(ST_USER_MISSING, NONE, 1'b1);
        return;
      end
      last_f = -1;
      for (int f = 0; f < FILES; f++) begin
        if (file_slot_used[u * FILES + f]) last_f = f;
      end
      if (last_f < 0) begin
        add_reply(ST_LIST_EMPTY, NONE, 1'b1);
        return;
      end
      for (int f = 0; f <= last_f; f++) begin
        if (file_slot_used[u * FILES + f]) begin
          add_reply(ST_ENTRY, file_slot_key[u * FILES + f], f == last_f);
        end
      end
      return;
    end
    if (fkey == '0) begin
      add_reply(ST_BAD, NONE, 1'b1);
      return;
    end
    if (u < 0 && fn == FN_DELETE) begin
      add_reply(ST_USER_MISSING, NONE, 1'b1);
      return;
    end
    if (u < 0) begin
      for (int i = 0; i < USERS; i++) begin
        if (u < 0 && user_slot_key[i] == '0) begin
          user_slot_key[i] = ukey;
          u = i;
        end
      end
      if (u < 0) begin
        add_reply(ST_NO_USER_SLOT, NONE, 1'b1);
        return;
      end
    end
    hit    = -1;
    free_f = -1;
    for (int f = 0; f < FILES; f++) begin
      if (hit < 0 && file_slot_used[u * FILES + f] && file_slot_key[u * FILES + f] == fkey)
        hit = u * FILES + f;
      if (free_f < 0 && !file_slot_used[u * FILES + f]) free_f = u * FILES + f;
    end
    if (fn == FN_DELETE) begin
      if (hit < 0) begin
        add_reply(ST_FILE_MISSING, NONE, 1'b1);
      end else begin
        file_slot_used[hit] = 1'b0;
        add_reply(ST_DELETED, NONE, 1'b1);
      end
    end else if (hit >= 0) begin
      add_reply(ST_EXISTS, NONE, 1'b1);
    end else if (free_f < 0) begin
      add_reply(ST_DIR_FULL, NONE, 1'b1);
    end else begin
      file_slot_key[free_f]  = fkey;
      file_slot_used[free_f] = 1'b1;
      add_reply(ST_CREATED, NONE, 1'b1);
    end
  endfunction

  // Presents one request after an idle gap and returns once it has been taken.
  task automatic issue_request(input func_t fn, input logic [KEY_W-1:0] ukey,
                               input logic [KEY_W-1:0] fkey, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_func     <= fn;
    in_user_key <= ukey;
    in_file_key <= fkey;
    do @(posedge clk); while (busy);
    run_directory_op(fn, ukey, fkey);
  endtask

  function automatic int idle_gap(int n);
    if ((n / 40) % 3 == 2) return 0;
    return $urandom_range(0, 9);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d key %h last %b",
                   out_status, out_entry_key, out_last);
      end else begin
        seen_reply = pending_replies.pop_front();
        if (out_status !== seen_reply.status || out_entry_key !== seen_reply.key ||
            out_last !== seen_reply.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: status %0d/%0d key %h/%h last %b/%b (expected/actual)",
                     seen_reply.status, out_status, seen_reply.key, out_entry_key,
                     seen_reply.last, out_last);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("two_level_directory_table verification failed");
    $finish;
  end

  initial begin
    func_t            fn;
    logic [KEY_W-1:0] ukey;
    logic [KEY_W-1:0] fkey;
    int               pick;
    int               n;
    reply_t           typed_reply;

    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_func     <= FN_CREATE;
    in_user_key <= '0;
    in_file_key <= '0;
    mismatches  = 0;
    for (int i = 0; i < USERS; i++) user_slot_key[i] = '0;
    for (int i = 0; i < SLOTS; i++) begin
      file_slot_key[i]  = '0;
      file_slot_used[i] = 1'b0;
    end

    plan = '{
      '{FN_LIST,   KEY_A, F_ONE, 1'b1, ST_USER_MISSING, NONE,  1'b1},
      '{FN_DELETE, KEY_A, F_ONE, 1'b1, ST_USER_MISSING, NONE,  1'b1},
      '{FN_UNUSED, KEY_A, F_ONE, 1'b1, ST_BAD,          NONE,  1'b1},
      '{FN_CREATE, NONE,  F_ONE, 1'b1, ST_BAD,          NONE,  1'b1},
      '{FN_CREATE, KEY_A, NONE,  1'b1, ST_BAD,          NONE,  1'b1},
      '{FN_DELETE, KEY_A, NONE,  1'b1, ST_BAD,          NONE,  1'b1},
      '{FN_LIST,   NONE,  F_ONE, 1'b1, ST_BAD,          NONE,  1'b1},
      '{FN_CREATE, KEY_A, F_TOP, 1'b1, ST_CREATED,      NONE,  1'b1},
      '{FN_CREATE, KEY_A, F_TOP, 1'b1, ST_EXISTS,       NONE,  1'b1},
      '{FN_LIST,   KEY_A, NONE,  1'b1, ST_ENTRY,        F_TOP, 1'b1},
      '{FN_CREATE, KEY_A, F_ONE, 1'b1, ST_CREATED,      NONE,  1'b1},
      '{FN_CREATE, KEY_B, F_MSB, 1'b1, ST_CREATED,      NONE,  1'b1},
      '{FN_LIST,   KEY_A, F_MSB, 1'b0, ST_ENTRY,        NONE,  1'b0},
      '{FN_DELETE, KEY_A, F_TOP, 1'b1, ST_DELETED,      NONE,  1'b1},
      '{FN_DELETE, KEY_A, F_TOP, 1'b1, ST_FILE_MISSING, NONE,  1'b1},
      '{FN_DELETE, KEY_B, F_ONE, 1'b1, ST_FILE_MISSING, NONE,  1'b1},
      '{FN_LIST,   KEY_A, F_TOP, 1'b0, ST_ENTRY,        NONE,  1'b0},
      '{FN_DELETE, KEY_A, F_ONE, 1'b1, ST_DELETED,      NONE,  1'b1},
      '{FN_LIST,   KEY_A, NONE,  1'b1, ST_LIST_EMPTY,   NONE,  1'b1},
      '{FN_LIST,   KEY_C, F_ONE, 1'b1, ST_USER_MISSING, NONE,  1'b1},
      '{FN_UNUSED, NONE,  NONE,  1'b1, ST_BAD,          NONE,  1'b1},
      '{FN_LIST,   KEY_B, F_ONE, 1'b0, ST_ENTRY,        NONE,  1'b0}
    };

    user_pool[0] = KEY_A;
    user_pool[1] = KEY_B;
    user_pool[2] = KEY_C;
    for (int i = 3; i < USER_POOL; i++) begin
      user_pool[i] = {$urandom, $urandom};
      if (user_pool[i] == '0) user_pool[i] = 64'd2;
    end
    file_pool[0] = F_TOP;
    file_pool[1] = F_ONE;
    file_pool[2] = F_MSB;
    for (int i = 3; i < FILE_POOL; i++) begin
      file_pool[i] = {$urandom, $urandom};
      if (file_pool[i] == '0) file_pool[i] = 64'd3;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    n = 0;
    for (int r = 0; r < PLAN_ROWS; r++) begin
      issue_request(plan[r].fn, plan[r].ukey, plan[r].fkey, idle_gap(n));
      n++;
      if (plan[r].typed) begin
        typed_reply.status = plan[r].status;
        typed_reply.key    = plan[r].key;
        typed_reply.last   = plan[r].last;
        pending_replies.push_back(typed_reply);
      end else begin
        foreach (op_replies[k]) pending_replies.push_back(op_replies[k]);
      end
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 6) ukey = user_pool[$urandom_range(0, 2)];
      else ukey = user_pool[$urandom_range(0, USER_POOL - 1)];
      fkey = file_pool[$urandom_range(0, FILE_POOL - 1)];
      if (pick < 8) begin
        case ($urandom_range(0, 3))
          0: begin
            fn   = FN_UNUSED;
            ukey = {$urandom, $urandom};
            fkey = {$urandom, $urandom};
          end
          1: begin
            fn   = func_t'($urandom_range(0, 2));
            ukey = '0;
          end
          2: begin
            fn   = func_t'($urandom_range(0, 1));
            fkey = '0;
          end
          default: begin
            fn   = func_t'($urandom_range(0, 2));
            ukey = {$urandom, $urandom};
            fkey = {$urandom, $urandom};
          end
        endcase
      end else if (pick < 62) begin
        fn = FN_CREATE;
      end else if (pick < 80) begin
        fn = FN_DELETE;
      end else begin
        fn = FN_LIST;
      end
      issue_request(fn, ukey, fkey, idle_gap(n));
      n++;
      foreach (op_replies[k]) pending_replies.push_back(op_replies[k]);
    end

    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("two_level_directory_table verification clean");
    end else begin
      $display("two_level_directory_table verification failed");
    end
    $finish;
  end

endmodule
